// ----- rtl/efv_pkg.sv -----
// shared types and constants of the ellipse fan vertex generator
`default_nettype none

package efv_pkg;

  localparam int unsigned SEGMENTS_DEF = 32;

  localparam int unsigned ANGLE_W = 16;
  localparam int unsigned COORD_W = 16;
  localparam int unsigned AXIS_W  = 15;
  localparam int unsigned TRIG_W  = 16;
  localparam int unsigned COLOR_W = 8;
  localparam int unsigned IDX_W   = 24;

  // angle offsets in 1/65536 turn
  localparam logic [ANGLE_W-1:0] QUARTER_TURN = 16'h4000;
  localparam logic [ANGLE_W-1:0] GREEN_SHIFT  = 16'd21823;
  localparam logic [ANGLE_W-1:0] BLUE_SHIFT   = 16'd43680;

  // quarter wave sine polynomial coefficients
  localparam logic [14:0] POLY_A = 15'd25736;
  localparam logic [14:0] POLY_B = 15'd10512;
  localparam logic [14:0] POLY_C = 15'd1160;

  typedef struct packed {
    logic signed [COORD_W-1:0] center_x;
    logic signed [COORD_W-1:0] center_y;
    logic [AXIS_W-1:0]         major_axis;
    logic [AXIS_W-1:0]         minor_axis;
    logic [ANGLE_W-1:0]        rotation;
  } efv_in_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] vertex_x;
    logic signed [COORD_W-1:0] vertex_y;
    logic [COLOR_W-1:0]        red;
    logic [COLOR_W-1:0]        green;
    logic [COLOR_W-1:0]        blue;
    logic [IDX_W-1:0]          vertex_index;
    logic [IDX_W-1:0]          fan_center_index;
    logic [IDX_W-1:0]          fan_this_index;
    logic [IDX_W-1:0]          fan_next_index;
    logic                      has_triangle;
    logic                      last;
  } efv_out_t;

endpackage

`default_nettype wire

// ----- rtl/efv_stream_if.sv -----
// valid/ready stream interface carrying one payload struct
`default_nettype none

interface efv_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/ellipse_fan_vertex_generator.sv -----
// Ellipse fan vertex generator: one ellipse in, SEGMENTS+1 fan vertices out (center first).
// All arithmetic runs through one shared 32x17 signed multiplier under a small sequencer.
// Each sine or cosine takes four multiplier passes (quarter wave polynomial). The setup
// of an ellipse computes the rotation cosine and sine and the green and blue cosines, the
// center vertex is loaded next, and every rim vertex takes two sines, eight multiply or
// rounding steps and one output load. A new ellipse is accepted only in idle, after the
// last rim vertex is loaded; in_ch.ready is low while an ellipse is in work. The result
// register lets the last vertex wait while the next ellipse is taken.
`default_nettype none

module ellipse_fan_vertex_generator
  import efv_pkg::*;
#(
  parameter int unsigned SEGMENTS = SEGMENTS_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  efv_stream_if.sink     in_ch,
  efv_stream_if.source   out_ch
);

  localparam int unsigned SEG_W  = $clog2(SEGMENTS);
  localparam int unsigned T_STEP = 65536 / SEGMENTS;
  localparam int unsigned T_REM  = 65536 % SEGMENTS;
  localparam int unsigned ACC_W  = 49;
  localparam int unsigned RND_W  = ACC_W - 28;

  typedef enum logic [14:0] {
    ST_IDLE    = 15'b000000000000001,
    ST_SIN_Z2  = 15'b000000000000010,
    ST_SIN_IN  = 15'b000000000000100,
    ST_SIN_MID = 15'b000000000001000,
    ST_SIN_V   = 15'b000000000010000,
    ST_CENTER  = 15'b000000000100000,
    ST_MUL_A   = 15'b000000001000000,
    ST_MUL_B   = 15'b000000010000000,
    ST_X1      = 15'b000000100000000,
    ST_X2      = 15'b000001000000000,
    ST_X3      = 15'b000010000000000,
    ST_Y1      = 15'b000100000000000,
    ST_Y2      = 15'b001000000000000,
    ST_Y3      = 15'b010000000000000,
    ST_EMIT    = 15'b100000000000000
  } state_t;

  // which trig value the sine sequence is producing
  typedef enum logic [2:0] {
    J_COS_ROT,
    J_SIN_ROT,
    J_COS_GRN,
    J_COS_BLU,
    J_COS_T,
    J_SIN_T
  } job_t;

  state_t state_r, state_nxt;
  job_t   job_r;

  logic                      out_valid_r, out_valid_nxt;
  efv_out_t                  out_data_r;
  logic [IDX_W-1:0]          vertex_count_r;

  logic signed [COORD_W-1:0] cx_r, cy_r, x_r, y_r;
  logic [AXIS_W-1:0]         maj_r, mnr_r;
  logic [ANGLE_W-1:0]        rot_r, ang_r, t_r;
  logic [SEG_W-1:0]          rem_r, seg_r;
  logic signed [TRIG_W-1:0]  cr_r, sr_r, ct_r, st_r;
  logic [COLOR_W-1:0]        red_r, grn_r, blu_r;
  logic [IDX_W-1:0]          base_r, self_r;
  logic [14:0]               z2_r, tmp_r;
  logic signed [31:0]        pa_r, pb_r;
  logic signed [ACC_W-1:0]   acc_r;

  logic                      in_accept, out_load, seg_last;
  logic [14:0]               z_w, mag_w;
  logic signed [TRIG_W-1:0]  sin_w;
  logic [COLOR_W-1:0]        color_w;
  logic signed [31:0]        mul_a;
  logic signed [16:0]        mul_b;
  logic signed [ACC_W-1:0]   prod, rsum;
  logic signed [RND_W-1:0]   rnd;
  logic signed [COORD_W-1:0] ctr_sel, sat_w;
  logic signed [21:0]        coord;
  logic [SEG_W:0]            rem_sum;
  logic                      rem_wrap;
  logic [ANGLE_W-1:0]        t_next;
  logic [SEG_W-1:0]          rem_next;

  function automatic logic [COLOR_W-1:0] color8(input logic signed [TRIG_W-1:0] c);
    logic [23:0] cw;
    logic [23:0] scaled;
    cw     = {9'd0, c[14:0]};
    scaled = (cw << 8) - cw + 24'd8192;
    if (c <= 0) begin
      return '0;
    end
    return scaled[21:14];
  endfunction

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign in_accept    = in_ch.valid && (state_r == ST_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;
  assign out_load     = ((state_r == ST_CENTER) || (state_r == ST_EMIT)) &&
                        (!out_valid_r || out_ch.ready);
  assign seg_last     = (seg_r == SEG_W'(SEGMENTS - 1));

  // quarter wave folding
  always_comb begin
    z_w = ang_r[14] ? (15'h4000 - {1'b0, ang_r[13:0]}) : {1'b0, ang_r[13:0]};
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      ST_SIN_Z2: begin
        mul_a = 32'(z_w);
        mul_b = 17'(z_w);
      end
      ST_SIN_IN: begin
        mul_a = 32'(z2_r);
        mul_b = 17'(POLY_C);
      end
      ST_SIN_MID: begin
        mul_a = 32'(z2_r);
        mul_b = 17'(tmp_r);
      end
      ST_SIN_V: begin
        mul_a = 32'(z_w);
        mul_b = 17'(tmp_r);
      end
      ST_MUL_A: begin
        mul_a = 32'(maj_r);
        mul_b = $signed({ct_r[TRIG_W-1], ct_r});
      end
      ST_MUL_B: begin
        mul_a = 32'(mnr_r);
        mul_b = $signed({st_r[TRIG_W-1], st_r});
      end
      ST_X1: begin
        mul_a = pa_r;
        mul_b = $signed({cr_r[TRIG_W-1], cr_r});
      end
      ST_X2: begin
        mul_a = pb_r;
        mul_b = $signed({sr_r[TRIG_W-1], sr_r});
      end
      ST_Y1: begin
        mul_a = pa_r;
        mul_b = $signed({sr_r[TRIG_W-1], sr_r});
      end
      ST_Y2: begin
        mul_a = pb_r;
        mul_b = $signed({cr_r[TRIG_W-1], cr_r});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  always_comb begin
    mag_w   = prod[28:14];
    sin_w   = ang_r[15] ? -$signed({1'b0, mag_w}) : $signed({1'b0, mag_w});
    color_w = color8(sin_w);
  end

  // round to Q13 (floor after adding half), add center, saturate
  always_comb begin
    rsum    = acc_r + ACC_W'(64'd1 << 27);
    rnd     = rsum[ACC_W-1:28];
    ctr_sel = (state_r == ST_Y3) ? cy_r : cx_r;
    coord   = {ctr_sel[COORD_W-1], ctr_sel[COORD_W-1], ctr_sel[COORD_W-1],
               ctr_sel[COORD_W-1], ctr_sel[COORD_W-1], ctr_sel[COORD_W-1], ctr_sel} +
              {rnd[RND_W-1], rnd};
    if (coord > 22'sd32767) begin
      sat_w = 16'sh7FFF;
    end else if (coord < -22'sd32768) begin
      sat_w = 16'sh8000;
    end else begin
      sat_w = coord[COORD_W-1:0];
    end
  end

  // next rim angle floor((i+1)*65536/SEGMENTS) by remainder tracking
  always_comb begin
    rem_sum  = {1'b0, rem_r} + (SEG_W + 1)'(T_REM);
    rem_wrap = (rem_sum >= (SEG_W + 1)'(SEGMENTS));
    rem_next = rem_wrap ? SEG_W'(rem_sum - (SEG_W + 1)'(SEGMENTS)) : rem_sum[SEG_W-1:0];
    t_next   = t_r + ANGLE_W'(T_STEP) + ANGLE_W'(rem_wrap);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:    if (in_ch.valid) state_nxt = ST_SIN_Z2;
      ST_SIN_Z2:  state_nxt = ST_SIN_IN;
      ST_SIN_IN:  state_nxt = ST_SIN_MID;
      ST_SIN_MID: state_nxt = ST_SIN_V;
      ST_SIN_V: begin
        unique case (job_r)
          J_COS_BLU: state_nxt = ST_CENTER;
          J_SIN_T:   state_nxt = ST_MUL_A;
          default:   state_nxt = ST_SIN_Z2;
        endcase
      end
      ST_CENTER:  if (out_load) state_nxt = ST_SIN_Z2;
      ST_MUL_A:   state_nxt = ST_MUL_B;
      ST_MUL_B:   state_nxt = ST_X1;
      ST_X1:      state_nxt = ST_X2;
      ST_X2:      state_nxt = ST_X3;
      ST_X3:      state_nxt = ST_Y1;
      ST_Y1:      state_nxt = ST_Y2;
      ST_Y2:      state_nxt = ST_Y3;
      ST_Y3:      state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (out_load) begin
          state_nxt = seg_last ? ST_IDLE : ST_SIN_Z2;
        end
      end
      default:    state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      out_valid_r    <= 1'b0;
      vertex_count_r <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (in_accept) begin
        vertex_count_r <= vertex_count_r + IDX_W'(SEGMENTS + 1);
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (in_accept) begin
      cx_r   <= in_ch.data.center_x;
      cy_r   <= in_ch.data.center_y;
      maj_r  <= in_ch.data.major_axis;
      mnr_r  <= in_ch.data.minor_axis;
      rot_r  <= in_ch.data.rotation;
      ang_r  <= in_ch.data.rotation + QUARTER_TURN;
      job_r  <= J_COS_ROT;
      base_r <= vertex_count_r;
      self_r <= vertex_count_r + IDX_W'(1);
      seg_r  <= '0;
      t_r    <= '0;
      rem_r  <= '0;
    end

    unique case (state_r)
      ST_SIN_Z2:  z2_r  <= prod[28:14];
      ST_SIN_IN:  tmp_r <= POLY_B - prod[28:14];
      ST_SIN_MID: tmp_r <= POLY_A - prod[28:14];
      ST_SIN_V: begin
        unique case (job_r)
          J_COS_ROT: begin
            cr_r  <= sin_w;
            red_r <= color_w;
            ang_r <= rot_r;
            job_r <= J_SIN_ROT;
          end
          J_SIN_ROT: begin
            sr_r  <= sin_w;
            ang_r <= rot_r - GREEN_SHIFT + QUARTER_TURN;
            job_r <= J_COS_GRN;
          end
          J_COS_GRN: begin
            grn_r <= color_w;
            ang_r <= rot_r - BLUE_SHIFT + QUARTER_TURN;
            job_r <= J_COS_BLU;
          end
          J_COS_BLU: begin
            blu_r <= color_w;
            ang_r <= t_r + QUARTER_TURN;
            job_r <= J_COS_T;
          end
          J_COS_T: begin
            ct_r  <= sin_w;
            ang_r <= t_r;
            job_r <= J_SIN_T;
          end
          J_SIN_T: begin
            st_r <= sin_w;
          end
          default: begin
            st_r <= sin_w;
          end
        endcase
      end
      ST_MUL_A: pa_r  <= prod[31:0];
      ST_MUL_B: pb_r  <= prod[31:0];
      ST_X1:    acc_r <= prod;
      ST_X2:    acc_r <= acc_r - prod;
      ST_X3:    x_r   <= sat_w;
      ST_Y1:    acc_r <= prod;
      ST_Y2:    acc_r <= acc_r + prod;
      ST_Y3:    y_r   <= sat_w;
      default: begin
      end
    endcase

    if (out_load) begin
      out_data_r.red   <= red_r;
      out_data_r.green <= grn_r;
      out_data_r.blue  <= blu_r;
      if (state_r == ST_CENTER) begin
        out_data_r.vertex_x         <= cx_r;
        out_data_r.vertex_y         <= cy_r;
        out_data_r.vertex_index     <= base_r;
        out_data_r.fan_center_index <= '0;
        out_data_r.fan_this_index   <= '0;
        out_data_r.fan_next_index   <= '0;
        out_data_r.has_triangle     <= 1'b0;
        out_data_r.last             <= 1'b0;
      end else begin
        out_data_r.vertex_x         <= x_r;
        out_data_r.vertex_y         <= y_r;
        out_data_r.vertex_index     <= self_r;
        out_data_r.fan_center_index <= base_r;
        out_data_r.fan_this_index   <= self_r;
        out_data_r.fan_next_index   <= seg_last ? (base_r + IDX_W'(1)) : (self_r + IDX_W'(1));
        out_data_r.has_triangle     <= 1'b1;
        out_data_r.last             <= seg_last;
        // step to the next rim point
        seg_r  <= seg_r + SEG_W'(1);
        self_r <= self_r + IDX_W'(1);
        t_r    <= t_next;
        rem_r  <= rem_next;
        ang_r  <= t_next + QUARTER_TURN;
        job_r  <= J_COS_T;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/efv_checker.sv -----
// port-level checks of the ellipse fan vertex generator and their bind
`default_nettype none

module efv_checker
  import efv_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             in_valid,
  input wire logic             in_ready,
  input wire logic             out_valid,
  input wire logic             out_ready,
  input wire logic             out_last,
  input wire logic             out_has_triangle,
  input wire logic [IDX_W-1:0] out_vertex_index,
  input wire logic [IDX_W-1:0] out_fan_this_index,
  input wire logic [IDX_W-1:0] out_fan_next_index
);

  // one ellipse at a time: busy right after a transaction on the input
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken again right after a transaction");

  // when idle, any pending result is the final rim vertex of the previous fan
  a_idle_shows_last: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ready && out_valid) |-> out_last)
    else $error("idle while a non-final vertex is pending");

  // the center vertex never closes a fan
  a_center_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_has_triangle) |-> !out_last)
    else $error("center vertex flagged last");

  // inner rim triangles point at the following rim vertex
  a_next_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_has_triangle && !out_last) |->
      (out_fan_next_index == IDX_W'(out_fan_this_index + IDX_W'(1))))
    else $error("rim triangle next index mismatch");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_vertex_index)))
    else $error("result changed while stalled");

endmodule

bind ellipse_fan_vertex_generator efv_checker u_efv_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_ch.valid),
  .in_ready           (in_ch.ready),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .out_last           (out_ch.data.last),
  .out_has_triangle   (out_ch.data.has_triangle),
  .out_vertex_index   (out_ch.data.vertex_index),
  .out_fan_this_index (out_ch.data.fan_this_index),
  .out_fan_next_index (out_ch.data.fan_next_index)
);

`default_nettype wire

// ----- bench/tb_top.sv -----
// self-checking testbench for the ellipse fan vertex generator
module tb_top;
  import efv_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NSEG = SEGMENTS_DEF;
  localparam int HOLD_CYCLES = 2000;
  localparam int DRAIN_CYCLES = 600;
  localparam int ITEMS_PER_PHASE = 44;

  typedef enum logic [1:0] {
    IDLE_RECV_HEAVY,
    IDLE_SEND_HEAVY,
    IDLE_NONE
  } idle_mode_t;

  logic clk = 1'b0;
  logic rst_n;

  efv_stream_if #(.T(efv_in_t))  in_ch ();
  efv_stream_if #(.T(efv_out_t)) out_ch ();

  ellipse_fan_vertex_generator #(
    .SEGMENTS(NSEG)
  ) u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always #10 clk = ~clk;

  efv_in_t          pending_ellipses[$];
  efv_out_t         fan_vertices_due[$];
  logic [IDX_W-1:0] vertex_counter = '0;
  idle_mode_t       idle_mode = IDLE_RECV_HEAVY;
  logic             hold_req = 1'b0;
  logic             hold_done;
  int               hold_left;
  int               mismatch_count = 0;
  int               ellipses_sent = 0;
  int               vertices_seen = 0;

  // quarter wave polynomial sine, Q14 result, angle in 1/65536 turn
  function automatic int q14_sin(logic [ANGLE_W-1:0] ang);
    logic [1:0] quad;
    int unsigned z, z2, inner, mid, mag;
    quad  = ang[15:14];
    z     = quad[0] ? (32'h4000 - ang[13:0]) : ang[13:0];
    z2    = (z * z) >> 14;
    inner = POLY_B - ((z2 * POLY_C) >> 14);
    mid   = POLY_A - ((z2 * inner) >> 14);
    mag   = (z * mid) >> 14;
    return quad[1] ? -int'(mag) : int'(mag);
  endfunction

  function automatic int q14_cos(logic [ANGLE_W-1:0] ang);
    return q14_sin(ang + QUARTER_TURN);
  endfunction

  function automatic logic [COLOR_W-1:0] color_level(logic [ANGLE_W-1:0] ang);
    int c;
    c = q14_cos(ang);
    if (c <= 0) return '0;
    return COLOR_W'((c * 255 + 8192) >> 14);
  endfunction

  // Q41 to Q13, ties go up; an arithmetic shift floors negatives as well
  function automatic longint round_q13(longint v);
    return (v + (longint'(1) <<< 27)) >>> 28;
  endfunction

  function automatic logic signed [COORD_W-1:0] clamp_coord(longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return COORD_W'(v);
  endfunction

  // queues the center vertex and every rim vertex of one ellipse
  function automatic void build_fan(efv_in_t e);
    efv_out_t         v;
    logic [COLOR_W-1:0] r, g, b;
    logic [ANGLE_W-1:0] t;
    logic [IDX_W-1:0] base;
    int               cr, sr, ct, st;
    longint           maj, mnr, dx, dy;
    base = vertex_counter;
    r    = color_level(e.rotation);
    g    = color_level(e.rotation - GREEN_SHIFT);
    b    = color_level(e.rotation - BLUE_SHIFT);
    cr   = q14_cos(e.rotation);
    sr   = q14_sin(e.rotation);
    maj  = longint'(e.major_axis);
    mnr  = longint'(e.minor_axis);
    v = '0;
    v.vertex_x     = e.center_x;
    v.vertex_y     = e.center_y;
    v.red          = r;
    v.green        = g;
    v.blue         = b;
    v.vertex_index = base;
    fan_vertices_due.push_back(v);
    for (int i = 0; i < NSEG; i++) begin
      t  = ANGLE_W'((i * 65536) / NSEG);
      ct = q14_cos(t);
      st = q14_sin(t);
      dx = maj * ct * cr - mnr * st * sr;
      dy = maj * ct * sr + mnr * st * cr;
      v.vertex_x         = clamp_coord(longint'($signed(e.center_x)) + round_q13(dx));
      v.vertex_y         = clamp_coord(longint'($signed(e.center_y)) + round_q13(dy));
      v.vertex_index     = base + IDX_W'(1 + i);
      v.fan_center_index = base;
      v.fan_this_index   = base + IDX_W'(1 + i);
      v.fan_next_index   = base + IDX_W'(1 + (i + 1) % NSEG);
      v.has_triangle     = 1'b1;
      v.last             = (i == NSEG - 1);
      fan_vertices_due.push_back(v);
    end
    vertex_counter = base + IDX_W'(NSEG + 1);
  endfunction

  function automatic void compare_field(string name, longint want, longint got);
    if (want != got) begin
      mismatch_count++;
      $display("[%0t] %s: expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  function automatic void check_vertex(efv_out_t got);
    efv_out_t want;
    if (fan_vertices_due.size() == 0) begin
      mismatch_count++;
      $display("[%0t] unexpected vertex: expected none, actual %h", $time, got);
      return;
    end
    want = fan_vertices_due.pop_front();
    compare_field("vertex_x", $signed(want.vertex_x), $signed(got.vertex_x));
    compare_field("vertex_y", $signed(want.vertex_y), $signed(got.vertex_y));
    compare_field("red", want.red, got.red);
    compare_field("green", want.green, got.green);
    compare_field("blue", want.blue, got.blue);
    compare_field("vertex_index", want.vertex_index, got.vertex_index);
    compare_field("fan_center_index", want.fan_center_index, got.fan_center_index);
    compare_field("fan_this_index", want.fan_this_index, got.fan_this_index);
    compare_field("fan_next_index", want.fan_next_index, got.fan_next_index);
    compare_field("has_triangle", want.has_triangle, got.has_triangle);
    compare_field("last", want.last, got.last);
  endfunction

  function automatic bit send_gap();
    case (idle_mode)
      IDLE_RECV_HEAVY: return $urandom_range(99) < 15;
      IDLE_SEND_HEAVY: return $urandom_range(99) < 85;
      default:         return 1'b0;
    endcase
  endfunction

  function automatic bit recv_gap();
    case (idle_mode)
      IDLE_RECV_HEAVY: return $urandom_range(99) < 85;
      IDLE_SEND_HEAVY: return $urandom_range(99) < 15;
      default:         return 1'b0;
    endcase
  endfunction

  function automatic efv_in_t ellipse(int cx, int cy, int maj, int mnr, int rot);
    efv_in_t e;
    e.center_x   = COORD_W'(cx);
    e.center_y   = COORD_W'(cy);
    e.major_axis = AXIS_W'(maj);
    e.minor_axis = AXIS_W'(mnr);
    e.rotation   = ANGLE_W'(rot);
    return e;
  endfunction

  // mostly in-range shapes near the origin, some full-range centers and oversized axes
  function automatic efv_in_t random_ellipse();
    efv_in_t e;
    if ($urandom_range(99) < 60) begin
      e.center_x = COORD_W'(int'($urandom_range(16384)) - 8192);
      e.center_y = COORD_W'(int'($urandom_range(16384)) - 8192);
    end else begin
      e.center_x = COORD_W'($urandom);
      e.center_y = COORD_W'($urandom);
    end
    if ($urandom_range(99) < 80) begin
      e.major_axis = AXIS_W'($urandom_range(16384));
      e.minor_axis = AXIS_W'($urandom_range(16384));
    end else begin
      e.major_axis = AXIS_W'($urandom);
      e.minor_axis = AXIS_W'($urandom);
    end
    e.rotation = ANGLE_W'($urandom);
    return e;
  endfunction

  // input side: predict on every accepted transaction, then offer the next ellipse
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.data  <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        build_fan(in_ch.data);
        ellipses_sent++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_ellipses.size() != 0 && !send_gap()) begin
          in_ch.data  <= pending_ellipses.pop_front();
          in_ch.valid <= 1'b1;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // long output stall, started once on request
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // output side
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        check_vertex(out_ch.data);
        vertices_seen++;
      end
      out_ch.ready <= (hold_left == 0) && !recv_gap();
    end
  end

  task automatic wait_inputs_taken();
    while (pending_ellipses.size() != 0 || in_ch.valid) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    rst_n        = 1'b0;

    // zero shape, full axes, every quadrant of rotation, color shift angles
    pending_ellipses.push_back(ellipse(0, 0, 0, 0, 0));
    pending_ellipses.push_back(ellipse(0, 0, 16384, 16384, 0));
    pending_ellipses.push_back(ellipse(0, 0, 16384, 4096, 16384));
    pending_ellipses.push_back(ellipse(0, 0, 4096, 16384, 32768));
    pending_ellipses.push_back(ellipse(0, 0, 16384, 0, 49152));
    pending_ellipses.push_back(ellipse(0, 0, 0, 16384, 65535));
    pending_ellipses.push_back(ellipse(1000, -1000, 8192, 8192, 1));
    pending_ellipses.push_back(ellipse(0, 0, 12000, 3000, 21823));
    pending_ellipses.push_back(ellipse(0, 0, 12000, 3000, 43680));
    pending_ellipses.push_back(ellipse(-1, 1, 1, 1, 8192));
    // saturation at both ends of the coordinate range
    pending_ellipses.push_back(ellipse(32767, 32767, 16384, 16384, 0));
    pending_ellipses.push_back(ellipse(-32768, -32768, 16384, 16384, 32768));
    pending_ellipses.push_back(ellipse(32767, -32768, 16384, 16384, 24576));
    pending_ellipses.push_back(ellipse(-32768, 32767, 16384, 16384, 57344));
    // axes beyond the nominal range use all 15 bits
    pending_ellipses.push_back(ellipse(0, 0, 32767, 32767, 0));
    pending_ellipses.push_back(ellipse(0, 0, 32767, 32767, 40000));
    pending_ellipses.push_back(ellipse(0, 0, 32767, 0, 12345));
    pending_ellipses.push_back(ellipse(0, 0, 0, 32767, 54321));
    pending_ellipses.push_back(ellipse(16383, -16384, 21845, 10922, 43690));
    pending_ellipses.push_back(ellipse(-21846, 21845, 10922, 21845, 21845));
    repeat (ITEMS_PER_PHASE) pending_ellipses.push_back(random_ellipse());

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    wait_inputs_taken();
    idle_mode <= IDLE_SEND_HEAVY;
    repeat (ITEMS_PER_PHASE) pending_ellipses.push_back(random_ellipse());

    wait_inputs_taken();
    idle_mode <= IDLE_NONE;
    hold_req  <= 1'b1;
    repeat (ITEMS_PER_PHASE) pending_ellipses.push_back(random_ellipse());

    wait_inputs_taken();
    while (fan_vertices_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d ellipses sent, %0d fan vertices compared", ellipses_sent, vertices_seen);
    $display("idle patterns: receiver heavy, sender heavy, none; one %0d cycle output stall",
             HOLD_CYCLES);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d field errors", mismatch_count);
      $display("Mismatches found");
    end
    $finish;
  end

  // 30 ms, well beyond the slowest legal run
  initial begin
    #30_000_000;
    $display("timeout with %0d vertices outstanding", fan_vertices_due.size());
    $display("Mismatches found");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/efv_pkg.sv
rtl/efv_stream_if.sv
rtl/ellipse_fan_vertex_generator.sv
rtl/efv_checker.sv
bench/tb_top.sv
